[design/text_console_engine_assert.svh]
// Assertion macros shared by the text console engine RTL
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TCE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tce_pkg.sv]
// Types and constants of the text console engine
package tce_pkg;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int XCUR_W  = 7;
    localparam int YCUR_W  = 6;
    localparam int COLS_W  = 8;
    localparam int ROWS_W  = 7;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 1;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    typedef enum logic [2:0] {
        OP_PRINT      = 3'd0,
        OP_BACKSPACE  = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_PUT        = 3'd3,
        OP_SET_CURSOR = 3'd4,
        OP_SET_COLORS = 3'd5,
        OP_READ       = 3'd6
    } op_t;

    localparam logic [IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [IDX_W-1:0] REG_ROWS    = 1'b1;

    localparam logic [CHAR_W-1:0]  CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;

    localparam logic [COLOR_W-1:0] DEFAULT_FORE = 4'd7;
    localparam logic [COLOR_W-1:0] DEFAULT_BACK = 4'd0;
    localparam logic [COLS_W-1:0]  RESET_COLUMNS = 8'd80;
    localparam logic [ROWS_W-1:0]  RESET_ROWS    = 7'd30;

    typedef struct packed {
        logic [2:0]         operation;
        logic [CHAR_W-1:0]  char_code;
        logic [XCUR_W-1:0]  column;
        logic [YCUR_W-1:0]  row;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
    } cmd_t;

    typedef struct packed {
        logic [XCUR_W-1:0]  cursor_column;
        logic [YCUR_W-1:0]  cursor_row;
        logic [CHAR_W-1:0]  cell_char;
        logic [ATTR_W-1:0]  cell_attr;
    } rsp_t;

    // raster walker control
    typedef struct packed {
        logic start;
        logic step;
    } walk_ctl_t;

endpackage

[design/tce_walker.sv]
// Raster counter that steps over a block of rows and columns of the cell store
module tce_walker #(
    parameter int CW = 7,
    parameter int RW = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tce_pkg::walk_ctl_t  ctl,
    input  logic [RW-1:0]       first_row,
    input  logic [RW-1:0]       last_row,
    input  logic [CW-1:0]       end_col,
    output logic [CW-1:0]       pos_col,
    output logic [RW-1:0]       pos_row,
    output logic                done
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] last_row_reg, last_row_next;
    logic [CW-1:0] end_col_reg, end_col_next;

    assign pos_col = col_reg;
    assign pos_row = row_reg;
    assign done    = (row_reg == last_row_reg) && (col_reg == end_col_reg);

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        last_row_next = last_row_reg;
        end_col_next  = end_col_reg;
        if (ctl.start) begin
            col_next      = '0;
            row_next      = first_row;
            last_row_next = last_row;
            end_col_next  = end_col;
        end else if (ctl.step) begin
            if (col_reg == end_col_reg) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_row_reg <= '0;
            end_col_reg  <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_row_reg <= last_row_next;
            end_col_reg  <= end_col_next;
        end
    end

endmodule

[design/text_console_engine.sv]
// Text console engine: cell store, cursor, colors, scroll and clear sequencer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  s_      | in        | s_valid / s_ready  | s_data (tce_pkg::cmd_t)
//  m_      | out       | m_valid / m_ready  | m_data (tce_pkg::rsp_t)
//  cfg_    | in        | cfg_we, no wait    | cfg_index, cfg_wdata
//
// Plain commands: accept (cell write or read issue), then result.
// Scroll: copy rows 1..rows-2 up, drain (both skipped below 3 rows), blank
//   row rows-2, result; rate is set by the single write port of the cell store.
// Clear: fill of all rows*cols cells with blanks, then result.
// Reset leaves the cell store unwritten; cursor 0,0, colors 7 on 0, 80x30 grid.
// A result waiting on m_ready holds the sequencer in its result state only.
`include "text_console_engine_assert.svh"

module text_console_engine #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tce_pkg::cmd_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tce_pkg::rsp_t                 m_data,
    input  logic                          cfg_we,
    input  logic [tce_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int EFF_COLS  = (MAX_COLS > 128) ? 128 : MAX_COLS;
    localparam int EFF_ROWS  = (MAX_ROWS > 64) ? 64 : MAX_ROWS;
    localparam int CW        = $clog2(EFF_COLS);
    localparam int RW        = $clog2(EFF_ROWS);
    localparam int AW        = CW + RW;
    localparam int MEM_DEPTH = 1 << AW;

    localparam logic [tce_pkg::COLS_W-1:0] EFF_COLS_V = tce_pkg::COLS_W'(EFF_COLS);
    localparam logic [tce_pkg::ROWS_W-1:0] EFF_ROWS_V = tce_pkg::ROWS_W'(EFF_ROWS);
    localparam logic [tce_pkg::COLS_W-1:0] RST_COLS =
        (tce_pkg::RESET_COLUMNS > EFF_COLS_V) ? EFF_COLS_V : tce_pkg::RESET_COLUMNS;
    localparam logic [tce_pkg::ROWS_W-1:0] RST_ROWS =
        (tce_pkg::RESET_ROWS > EFF_ROWS_V) ? EFF_ROWS_V : tce_pkg::RESET_ROWS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COPY  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tce_pkg::COLS_W-1:0]  cols_reg, cols_next;
    logic [tce_pkg::ROWS_W-1:0]  rows_reg, rows_next;
    logic [tce_pkg::XCUR_W-1:0]  cx_reg, cx_next;
    logic [tce_pkg::YCUR_W-1:0]  cy_reg, cy_next;
    logic [tce_pkg::COLOR_W-1:0] fore_reg, fore_next;
    logic [tce_pkg::COLOR_W-1:0] back_reg, back_next;
    logic [tce_pkg::ATTR_W-1:0]  fill_attr_reg, fill_attr_next;
    logic                        pend_reg, pend_next;
    logic [tce_pkg::CHAR_W-1:0]  ch_reg, ch_next;
    logic                        rd_sel_reg, rd_sel_next;
    logic                        cp_vld_reg, cp_vld_next;
    logic [AW-1:0]               cp_addr_reg, cp_addr_next;
    logic                        m_valid_reg, m_valid_next;
    tce_pkg::rsp_t               m_data_reg, m_data_next;

    // cell store: {attribute, character}
    logic [tce_pkg::CELL_W-1:0]  cell_mem [MEM_DEPTH];
    logic [tce_pkg::CELL_W-1:0]  rd_data_reg;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [tce_pkg::CELL_W-1:0]  wr_data;

    // single-cell write request from a command
    logic                        w_req;
    logic [tce_pkg::XCUR_W-1:0]  w_col;
    logic [tce_pkg::YCUR_W-1:0]  w_row;
    logic [tce_pkg::CHAR_W-1:0]  w_char;
    logic [tce_pkg::ATTR_W-1:0]  w_attr;

    tce_pkg::walk_ctl_t          walk_ctl;
    logic [RW-1:0]               walk_first, walk_last, walk_row;
    logic [CW-1:0]               walk_col;
    logic                        walk_done;

    logic [tce_pkg::COLS_W-1:0]  x_inc;
    logic [tce_pkg::ROWS_W-1:0]  y_inc;
    logic                        is_lf, advance, scroll;
    logic [tce_pkg::XCUR_W-1:0]  bs_x;
    logic [tce_pkg::YCUR_W-1:0]  bs_y;
    logic [tce_pkg::ATTR_W-1:0]  cur_attr;
    logic                        read_hit;
    logic [tce_pkg::COLS_W-1:0]  cfg_cols_sat;
    logic [tce_pkg::ROWS_W-1:0]  cfg_rows_sat;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cur_attr = {back_reg, fore_reg};
    assign x_inc    = {1'b0, cx_reg} + 8'd1;
    assign y_inc    = {1'b0, cy_reg} + 7'd1;
    assign is_lf    = (s_data.char_code == tce_pkg::CH_LF);
    assign advance  = is_lf || (x_inc >= cols_reg);
    assign scroll   = (y_inc >= (rows_reg - 7'd1));

    // backspace from column 0 goes to cols-2 of the row above (row 0 stays put)
    assign bs_x = (cx_reg != '0) ? (cx_reg - 7'd1) :
                  (cols_reg >= 8'd2) ? tce_pkg::XCUR_W'(cols_reg - 8'd2) : '0;
    assign bs_y = ((cx_reg == '0) && (cy_reg != '0)) ? (cy_reg - 6'd1) : cy_reg;

    assign read_hit = ({1'b0, s_data.column} < cols_reg) && ({1'b0, s_data.row} < rows_reg);

    assign cfg_cols_sat = (cfg_wdata == '0) ? 8'd1 :
                          (cfg_wdata > EFF_COLS_V) ? EFF_COLS_V : cfg_wdata;
    assign cfg_rows_sat = (cfg_wdata[6:0] < 7'd2) ? 7'd2 :
                          (cfg_wdata[6:0] > EFF_ROWS_V) ? EFF_ROWS_V : cfg_wdata[6:0];

    tce_walker #(
        .CW (CW),
        .RW (RW)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (walk_ctl),
        .first_row (walk_first),
        .last_row  (walk_last),
        .end_col   (CW'(cols_reg - 8'd1)),
        .pos_col   (walk_col),
        .pos_row   (walk_row),
        .done      (walk_done)
    );

    always_comb begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        fill_attr_next = fill_attr_reg;
        pend_next      = pend_reg;
        ch_next        = ch_reg;
        rd_sel_next    = rd_sel_reg;
        cp_vld_next    = 1'b0;
        cp_addr_next   = cp_addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        w_req          = 1'b0;
        w_col          = '0;
        w_row          = '0;
        w_char         = '0;
        w_attr         = '0;
        walk_ctl       = '0;
        walk_first     = '0;
        walk_last      = '0;

        if (cfg_we) begin
            case (cfg_index)
                tce_pkg::REG_COLUMNS: cols_next = cfg_cols_sat;
                tce_pkg::REG_ROWS:    rows_next = cfg_rows_sat;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_RESP;
                    rd_sel_next = 1'b0;
                    case (s_data.operation)
                        tce_pkg::OP_PRINT: begin
                            if (s_data.char_code != tce_pkg::CH_CR) begin
                                if (advance) begin
                                    cx_next = is_lf ? 7'd0 : 7'd1;
                                    if (scroll) begin
                                        cy_next        = tce_pkg::YCUR_W'(rows_reg - 7'd2);
                                        pend_next      = !is_lf;
                                        ch_next        = s_data.char_code;
                                        fill_attr_next = cur_attr;
                                        walk_ctl.start = 1'b1;
                                        if (rows_reg >= 7'd3) begin
                                            walk_first = '0;
                                            walk_last  = RW'(rows_reg - 7'd3);
                                            state_next = ST_COPY;
                                        end else begin
                                            walk_first = RW'(rows_reg - 7'd2);
                                            walk_last  = RW'(rows_reg - 7'd2);
                                            state_next = ST_FILL;
                                        end
                                    end else begin
                                        cy_next = y_inc[5:0];
                                        w_req   = !is_lf;
                                        w_col   = '0;
                                        w_row   = y_inc[5:0];
                                        w_char  = s_data.char_code;
                                        w_attr  = cur_attr;
                                    end
                                end else begin
                                    w_req   = 1'b1;
                                    w_col   = cx_reg;
                                    w_row   = cy_reg;
                                    w_char  = s_data.char_code;
                                    w_attr  = cur_attr;
                                    cx_next = x_inc[6:0];
                                end
                            end
                        end
                        tce_pkg::OP_BACKSPACE: begin
                            cx_next = bs_x;
                            cy_next = bs_y;
                            w_req   = 1'b1;
                            w_col   = bs_x;
                            w_row   = bs_y;
                            w_char  = tce_pkg::CH_BLANK;
                            w_attr  = cur_attr;
                        end
                        tce_pkg::OP_CLEAR: begin
                            cx_next        = '0;
                            cy_next        = '0;
                            fore_next      = tce_pkg::DEFAULT_FORE;
                            back_next      = s_data.fore_color;
                            fill_attr_next = {s_data.fore_color, s_data.fore_color};
                            pend_next      = 1'b0;
                            walk_ctl.start = 1'b1;
                            walk_first     = '0;
                            walk_last      = RW'(rows_reg - 7'd1);
                            state_next     = ST_FILL;
                        end
                        tce_pkg::OP_PUT: begin
                            w_req  = 1'b1;
                            w_col  = s_data.column;
                            w_row  = s_data.row;
                            w_char = s_data.char_code;
                            w_attr = {s_data.back_color, s_data.fore_color};
                        end
                        tce_pkg::OP_SET_CURSOR: begin
                            cx_next = s_data.column;
                            cy_next = s_data.row;
                        end
                        tce_pkg::OP_SET_COLORS: begin
                            fore_next = s_data.fore_color;
                            back_next = s_data.back_color;
                        end
                        tce_pkg::OP_READ: begin
                            rd_sel_next = read_hit;
                            rd_en       = read_hit;
                            rd_addr     = {s_data.row[RW-1:0], s_data.column[CW-1:0]};
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY: begin
                // read row r+1 now, write it to row r next cycle
                rd_en         = 1'b1;
                rd_addr       = {walk_row + RW'(1), walk_col};
                cp_vld_next   = 1'b1;
                cp_addr_next  = {walk_row, walk_col};
                walk_ctl.step = 1'b1;
                if (walk_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                walk_ctl.start = 1'b1;
                walk_first     = RW'(rows_reg - 7'd2);
                walk_last      = RW'(rows_reg - 7'd2);
                state_next     = ST_FILL;
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = {walk_row, walk_col};
                // a wrapped print lands at column 0 of the freshly blanked row
                wr_data = {fill_attr_reg,
                           (pend_reg && (walk_col == '0)) ? ch_reg : tce_pkg::CH_BLANK};
                walk_ctl.step = 1'b1;
                if (walk_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.cursor_column = cx_reg;
                    m_data_next.cursor_row    = cy_reg;
                    m_data_next.cell_char     = rd_sel_reg ? rd_data_reg[7:0] : '0;
                    m_data_next.cell_attr     = rd_sel_reg ? rd_data_reg[15:8] : '0;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cp_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = cp_addr_reg;
            wr_data = rd_data_reg;
        end else if (w_req && ({1'b0, w_col} < cols_reg) && ({1'b0, w_row} < rows_reg)) begin
            wr_en   = 1'b1;
            wr_addr = {w_row[RW-1:0], w_col[CW-1:0]};
            wr_data = {w_attr, w_char};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cols_reg    <= RST_COLS;
            rows_reg    <= RST_ROWS;
            cx_reg      <= '0;
            cy_reg      <= '0;
            fore_reg    <= tce_pkg::DEFAULT_FORE;
            back_reg    <= tce_pkg::DEFAULT_BACK;
            cp_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            fore_reg    <= fore_next;
            back_reg    <= back_next;
            cp_vld_reg  <= cp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_attr_reg <= fill_attr_next;
        pend_reg      <= pend_next;
        ch_reg        <= ch_next;
        rd_sel_reg    <= rd_sel_next;
        cp_addr_reg   <= cp_addr_next;
        m_data_reg    <= m_data_next;
    end

    `TCE_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE, "accepted transaction did not leave idle")
    `TCE_ASSERT_NOW(a_copy_write_in_walk, aclk, aresetn, cp_vld_reg, state_reg == ST_COPY || state_reg == ST_DRAIN, "scroll copy write outside the scroll walk")
    `TCE_ASSERT_NOW(a_write_in_grid, aclk, aresetn, wr_en, (8'(wr_addr[CW-1:0]) < cols_reg) && (7'(wr_addr[AW-1:CW]) < rows_reg), "cell write outside the grid")
    `TCE_ASSERT_NOW(a_result_from_resp, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_RESP, "result appeared outside the result state")

endmodule
